@@ src/pu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pu_pkg
// Shared types, constants and lookup tables of the permutation unranking block.
// ----------------------------------------------------------------------------
package pu_pkg;

  localparam int MAX_ELEMS_DEF = 12;
  localparam int RANK_W        = 29;
  localparam int FIELD_W       = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 4;
  localparam int LIMIT_W       = RANK_W + 1;
  localparam int RECIP_W       = 32;
  localparam int TAB_IDX_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ELEMS_IN_USE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ONE_BASED    = CFG_IDX_W'(1);

  localparam logic [FIELD_W-1:0] ELEMS_RESET = FIELD_W'(12);

  typedef struct packed {
    logic [RANK_W-1:0] rank;
  } rank_t;

  typedef struct packed {
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] element_value;
    logic               last;
    logic               out_of_range;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic check;
    logic mul;
    logic fix;
    logic emit_err;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic range_err;
    logic div_done;
    logic emit_last;
    logic out_free;
  } ctrl_sts_t;

  // Factorials 0! to 20!; larger indexes read as saturated.
  localparam logic [63:0] FACT_TAB [0:31] = '{
    64'd1, 64'd1, 64'd2, 64'd6, 64'd24, 64'd120, 64'd720, 64'd5040,
    64'd40320, 64'd362880, 64'd3628800, 64'd39916800, 64'd479001600,
    64'd6227020800, 64'd87178291200, 64'd1307674368000,
    64'd20922789888000, 64'd355687428096000, 64'd6402373705728000,
    64'd121645100408832000, 64'd2432902008176640000,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF
  };

  // Scaled reciprocals floor((2^32 - 1) / k) for the divisors 1 to 20.
  localparam logic [RECIP_W-1:0] RECIP_TAB [0:31] = '{
    32'd0,
    32'hFFFF_FFFF / 1,  32'hFFFF_FFFF / 2,  32'hFFFF_FFFF / 3,  32'hFFFF_FFFF / 4,
    32'hFFFF_FFFF / 5,  32'hFFFF_FFFF / 6,  32'hFFFF_FFFF / 7,  32'hFFFF_FFFF / 8,
    32'hFFFF_FFFF / 9,  32'hFFFF_FFFF / 10, 32'hFFFF_FFFF / 11, 32'hFFFF_FFFF / 12,
    32'hFFFF_FFFF / 13, 32'hFFFF_FFFF / 14, 32'hFFFF_FFFF / 15, 32'hFFFF_FFFF / 16,
    32'hFFFF_FFFF / 17, 32'hFFFF_FFFF / 18, 32'hFFFF_FFFF / 19, 32'hFFFF_FFFF / 20,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  function automatic logic [LIMIT_W-1:0] fact_sat(input logic [TAB_IDX_W-1:0] n);
    logic [63:0] f;
    f = FACT_TAB[n];
    if (f > 64'(({LIMIT_W{1'b1}}))) begin
      fact_sat = {LIMIT_W{1'b1}};
    end else begin
      fact_sat = f[LIMIT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ src/pu_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pu_stream_if
// Valid/ready channel that moves one item of the given payload type.
// ----------------------------------------------------------------------------
interface pu_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/pu_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pu_ctrl
// Sequencer that steps the datapath through range check, digit split and
// element emission for one rank at a time.
// ----------------------------------------------------------------------------
module pu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rank_valid_i,
  output logic                   rank_ready_o,
  input  wire pu_pkg::ctrl_sts_t sts_i,
  output pu_pkg::ctrl_cmd_t      cmd_o
);
  import pu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_FIX,
    ST_ERR,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    rank_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rank_ready_o = 1'b1;
        if (rank_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.range_err ? ST_ERR : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = sts_i.div_done ? ST_EMIT : ST_MUL;
      end
      ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ src/pu_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pu_dp
// Datapath: configuration registers, range check, reciprocal divider for the
// factoradic digits, digit store, list of unused elements and result register.
// ----------------------------------------------------------------------------
module pu_dp #(
  parameter int MAX_ELEMS = pu_pkg::MAX_ELEMS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire pu_pkg::cfg_t      cfg_data_i,
  input  wire pu_pkg::rank_t     rank_data_i,
  input  wire pu_pkg::ctrl_cmd_t cmd_i,
  output pu_pkg::ctrl_sts_t      sts_o,
  output logic                   result_valid_o,
  output pu_pkg::result_t        result_data_o,
  input  wire logic              result_ready_i
);
  import pu_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMS + 1);
  localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int PROD_W = RANK_W + RECIP_W;

  logic [FIELD_W-1:0] elems_q;
  logic               one_based_q;

  logic [RANK_W-1:0]  rank_q;
  logic [CNT_W-1:0]   d_q;
  logic [CNT_W-1:0]   d_sel;
  logic               ob_q;
  logic [RANK_W-1:0]  q_q;
  logic [CNT_W-1:0]   div_q;
  logic [PROD_W-1:0]  prod_q;
  logic [IDX_W-1:0]   pos_q;
  logic [IDX_W-1:0]   digit_q  [MAX_ELEMS];
  logic [IDX_W-1:0]   unused_q [MAX_ELEMS];

  logic               out_valid_q;
  result_t            out_q;

  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] rank_ext;
  logic               range_err;
  logic [RANK_W-1:0]  q_est;
  logic [RANK_W-1:0]  q_back;
  logic [RANK_W-1:0]  rem_raw;
  logic [RANK_W-1:0]  div_ext;
  logic               rem_over;
  logic [RANK_W-1:0]  q_next;
  logic [RANK_W-1:0]  rem_fix;
  logic [CNT_W-1:0]   digit_pos;
  logic [IDX_W-1:0]   pick;
  logic [IDX_W-1:0]   elem;
  logic [IDX_W+3:0]   pos_ext;
  logic [CNT_W+3:0]   val_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elems_q     <= ELEMS_RESET;
      one_based_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_data_i.index == REG_ELEMS_IN_USE) begin
        elems_q <= cfg_data_i.wdata;
      end else if (cfg_data_i.index == REG_ONE_BASED) begin
        one_based_q <= cfg_data_i.wdata[0];
      end
    end
  end

  always_comb begin
    if (elems_q == '0) begin
      d_sel = CNT_W'(1);
    end else if (32'(elems_q) > MAX_ELEMS) begin
      d_sel = CNT_W'(MAX_ELEMS);
    end else begin
      d_sel = CNT_W'(elems_q);
    end
  end

  assign limit    = fact_sat(TAB_IDX_W'(d_q));
  assign rank_ext = {1'b0, rank_q};

  always_comb begin
    if (ob_q) begin
      range_err = (rank_q == '0) || (rank_ext > limit);
    end else begin
      range_err = (rank_ext >= limit);
    end
  end

  assign sts_o.range_err = range_err;

  assign q_est    = prod_q[PROD_W-1:RECIP_W];
  assign q_back   = RANK_W'(q_est * div_q);
  assign rem_raw  = q_q - q_back;
  assign div_ext  = RANK_W'(div_q);
  assign rem_over = (rem_raw >= div_ext);
  assign q_next   = rem_over ? (q_est + RANK_W'(1)) : q_est;
  assign rem_fix  = rem_over ? (rem_raw - div_ext) : rem_raw;
  assign digit_pos = d_q - div_q;

  assign pick    = digit_q[pos_q];
  assign elem    = unused_q[pick];
  assign pos_ext = (IDX_W + 4)'(pos_q);
  assign val_ext = (CNT_W + 4)'(elem) + (CNT_W + 4)'(ob_q);

  assign sts_o.div_done  = (div_q == d_q);
  assign sts_o.emit_last = (CNT_W'(pos_q) == d_q - CNT_W'(1));
  assign sts_o.out_free  = !out_valid_q || result_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rank_q <= rank_data_i.rank;
      d_q    <= d_sel;
      ob_q   <= one_based_q;
    end
    if (cmd_i.check) begin
      q_q   <= rank_q - RANK_W'(ob_q);
      div_q <= CNT_W'(1);
      pos_q <= '0;
      for (int j = 0; j < MAX_ELEMS; j++) begin
        unused_q[j] <= IDX_W'(j);
      end
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(q_q) * PROD_W'(RECIP_TAB[TAB_IDX_W'(div_q)]);
    end
    if (cmd_i.fix) begin
      digit_q[IDX_W'(digit_pos)] <= IDX_W'(rem_fix);
      q_q   <= q_next;
      div_q <= div_q + CNT_W'(1);
    end
    if (cmd_i.emit) begin
      for (int j = 0; j + 1 < MAX_ELEMS; j++) begin
        if (IDX_W'(j) >= pick) begin
          unused_q[j] <= unused_q[j + 1];
        end
      end
      pos_q <= pos_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      out_q.position      <= '0;
      out_q.element_value <= '0;
      out_q.last          <= 1'b1;
      out_q.out_of_range  <= 1'b1;
    end else if (cmd_i.emit) begin
      out_q.position      <= pos_ext[FIELD_W-1:0];
      out_q.element_value <= val_ext[FIELD_W-1:0];
      out_q.last          <= sts_o.emit_last;
      out_q.out_of_range  <= 1'b0;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_data_o  = out_q;

endmodule
`default_nettype wire

@@ src/permutation_unrank.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// permutation_unrank
// Decodes a rank into the permutation of d elements that it encodes.
// ----------------------------------------------------------------------------
// A rank is taken when the block is idle. A check state checks it against d!;
// a rank out of range yields a single flagged result. Otherwise the rank is
// split into d factoradic digits by a reciprocal multiplier and a correction
// step, a multiply state and a fix state per digit, and then one result per
// position leaves the output register each cycle that the sink takes it. The
// next rank is taken as soon as the last result of the current one sits in the
// output register. The element count and the one-based mode are sampled when a
// rank is taken.
module permutation_unrank #(
  parameter int MAX_ELEMS = pu_pkg::MAX_ELEMS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pu_stream_if.sink   cfg_i,
  pu_stream_if.sink   rank_i,
  pu_stream_if.source result_o
);
  import pu_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_i.ready = 1'b1;

  pu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rank_valid_i (rank_i.valid),
    .rank_ready_o (rank_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  pu_dp #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_data_i     (cfg_i.data),
    .rank_data_i    (rank_i.data),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_o.valid),
    .result_data_o  (result_o.data),
    .result_ready_i (result_o.ready)
  );

endmodule
`default_nettype wire

@@ dv/permutation_unrank_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// permutation_unrank_checker
// Watches the configuration, rank and result channels of the unranking block.
// It keeps its own copy of the element count and the one-based mode, and
// expands every accepted rank into the positions and elements that it
// encodes, or into one flagged place if it is out of range. Each accepted
// result is then compared field by field with the oldest expected place.
// ----------------------------------------------------------------------------
module permutation_unrank_checker
  import pu_pkg::*;
#(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_valid_i,
  input  logic    cfg_ready_i,
  input  cfg_t    cfg_i,
  input  logic    rank_valid_i,
  input  logic    rank_ready_i,
  input  rank_t   rank_i,
  input  logic    res_valid_i,
  input  logic    res_ready_i,
  input  result_t res_i,
  output int      mismatches_o,
  output int      outstanding_o
);

  logic [FIELD_W-1:0] elems_cfg;
  logic               base1_cfg;
  result_t            expected_places [$];
  int                 mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("[%0t] permutation_unrank mismatch: %s got %0d expected %0d",
               $time, what, got, want);
    end
  endtask

  function automatic void add_place(input result_t place);
    expected_places.insert(expected_places.size(), place);
  endfunction

  function automatic void expand_rank(input logic [RANK_W-1:0] rank);
    int unsigned     d;
    int unsigned     k;
    int unsigned     j;
    int unsigned     pick;
    int unsigned     pool_len;
    int unsigned     elem;
    longint unsigned bound;
    longint unsigned rest;
    int unsigned     digits [MAX_ELEMS];
    int unsigned     pool [MAX_ELEMS];
    result_t         place;

    d = elems_cfg;
    if (d == 0) d = 1;
    if (d > MAX_ELEMS) d = MAX_ELEMS;
    bound = 1;
    for (k = 2; k <= d; k++) bound = bound * k;
    rest = rank;

    if (base1_cfg ? (rest == 0 || rest > bound) : (rest >= bound)) begin
      place.position      = '0;
      place.element_value = '0;
      place.last          = 1'b1;
      place.out_of_range  = 1'b1;
      add_place(place);
      return;
    end
    if (base1_cfg) rest = rest - 1;

    // Lehmer digits, most significant first.
    for (k = 1; k <= d; k++) begin
      digits[d - k] = int'(rest % k);
      rest = rest / k;
    end
    for (k = 0; k < d; k++) pool[k] = k;

    pool_len = d;
    for (k = 0; k < d; k++) begin
      pick = digits[k];
      elem = pool[pick];
      for (j = pick; j + 1 < pool_len; j++) pool[j] = pool[j + 1];
      pool_len--;
      place.position      = FIELD_W'(k);
      place.element_value = FIELD_W'(elem + base1_cfg);
      place.last          = (k + 1 == d);
      place.out_of_range  = 1'b0;
      add_place(place);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elems_cfg = ELEMS_RESET;
      base1_cfg = 1'b0;
      expected_places.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_i.index)
          REG_ELEMS_IN_USE: elems_cfg = cfg_i.wdata;
          REG_ONE_BASED:    base1_cfg = cfg_i.wdata[0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_places.size() == 0) begin
          report("result with nothing expected, position", res_i.position, 0);
        end else begin
          result_t want;
          want = expected_places.pop_front();
          if (res_i.position !== want.position)
            report("position", res_i.position, want.position);
          if (res_i.element_value !== want.element_value)
            report("element_value", res_i.element_value, want.element_value);
          if (res_i.last !== want.last)
            report("last", res_i.last, want.last);
          if (res_i.out_of_range !== want.out_of_range)
            report("out_of_range", res_i.out_of_range, want.out_of_range);
        end
      end
      if (rank_valid_i && rank_ready_i) expand_rank(rank_i.rank);
      outstanding_o <= expected_places.size();
    end
  end

endmodule

@@ dv/permutation_unrank_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// permutation_unrank_tb
// Drives ranks into the unranking block under a series of element counts and
// base modes: first a directed set of edge ranks, then random ranks that are
// mostly valid. Both sides idle at random, and the result side holds off once
// for a long stretch so that the block backs up. The checker beside the block
// supplies the failure count for the verdict.
// ----------------------------------------------------------------------------
module permutation_unrank_tb;
  import pu_pkg::*;

  localparam int MAX_ELEMS = MAX_ELEMS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam logic [RANK_W-1:0] FACT_TWELVE = RANK_W'(479001600);
  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 35;
  localparam int unsigned PHASE_ELEMS [PHASES] = '{12, 1, 7, 15, 4, 0, 9, 12, 13, 2};

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   outstanding;
  bit   idle_on = 1'b1;
  bit   long_hold = 1'b0;
  int unsigned cur_d = 12;
  bit   cur_base1 = 1'b0;

  pu_stream_if #(.payload_t(cfg_t))    cfg_if ();
  pu_stream_if #(.payload_t(rank_t))   rank_if ();
  pu_stream_if #(.payload_t(result_t)) result_if ();

  permutation_unrank #(.MAX_ELEMS(MAX_ELEMS)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .rank_i   (rank_if),
    .result_o (result_if)
  );

  permutation_unrank_checker #(.MAX_ELEMS(MAX_ELEMS)) perm_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_i         (cfg_if.data),
    .rank_valid_i  (rank_if.valid),
    .rank_ready_i  (rank_if.ready),
    .rank_i        (rank_if.data),
    .res_valid_i   (result_if.valid),
    .res_ready_i   (result_if.ready),
    .res_i         (result_if.data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("permutation_unrank verification failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_t w;
    w.index = idx;
    w.wdata = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] elems, input bit base1);
    logic [CFG_DATA_W-2:0] pad;
    pad = (CFG_DATA_W - 1)'($urandom_range(0, 7));
    write_reg(REG_ELEMS_IN_USE, elems);
    write_reg(REG_ONE_BASED, {pad, base1});
    cfg_if.valid <= 1'b0;
    cur_d = (elems == 0) ? 1 : ((elems > MAX_ELEMS) ? MAX_ELEMS : elems);
    cur_base1 = base1;
  endtask

  task automatic send_rank(input logic [RANK_W-1:0] value);
    int unsigned gap;
    rank_t item;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      rank_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.rank = value;
    rank_if.valid <= 1'b1;
    rank_if.data  <= item;
    do @(posedge clk_i); while (!rank_if.ready);
  endtask

  task automatic drain();
    rank_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly valid ranks, with edges around the range and raw 29-bit noise.
  function automatic logic [RANK_W-1:0] next_rank(input int unsigned d, input bit base1);
    longint unsigned bound;
    int unsigned k;
    bound = 1;
    for (k = 2; k <= d; k++) bound = bound * k;
    case ($urandom_range(0, 9))
      0: return RANK_W'($urandom());
      1: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return RANK_W'(base1);
          2: return RANK_W'(bound - 1 + base1);
          3: return RANK_W'(bound + base1);
          default: return RANK_MAX;
        endcase
      end
      default: return RANK_W'($urandom_range(0, 32'(bound - 1)) + base1);
    endcase
  endfunction

  initial begin
    result_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      int unsigned stall;
      if (long_hold) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
    end
  end

  initial begin
    int p;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
    rank_if.valid <= 1'b0;
    rank_if.data  <= '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_SPARE_A, 4'hF);
    write_reg(REG_SPARE_B, 4'hA);
    configure(4'd12, 1'b0);
    send_rank('0);
    send_rank(RANK_W'(1));
    send_rank(FACT_TWELVE - 1);
    send_rank(FACT_TWELVE);
    send_rank(RANK_MAX);
    send_rank(RANK_W'(29'h1555_5555));
    send_rank(RANK_W'(29'h0AAA_AAAA));
    drain();

    configure(4'd12, 1'b1);
    send_rank('0);
    send_rank(RANK_W'(1));
    send_rank(FACT_TWELVE);
    send_rank(FACT_TWELVE + 1);
    drain();

    configure(4'd0, 1'b0);
    send_rank('0);
    send_rank(RANK_W'(1));
    drain();

    configure(4'd15, 1'b0);
    send_rank(FACT_TWELVE - 1);
    send_rank(FACT_TWELVE);
    drain();

    configure(4'd1, 1'b1);
    send_rank(RANK_W'(1));
    send_rank(RANK_W'(2));
    send_rank('0);
    drain();

    configure(4'd13, 1'b1);
    send_rank(FACT_TWELVE);
    drain();

    configure(4'd2, 1'b0);
    send_rank('0);
    send_rank(RANK_W'(1));
    send_rank(RANK_W'(2));

    for (p = 0; p < PHASES; p++) begin
      drain();
      configure(CFG_DATA_W'(PHASE_ELEMS[p]), p[0]);
      idle_on = (p != 3);
      if (p == 0) long_hold = 1'b1;
      repeat (PHASE_ITEMS) send_rank(next_rank(cur_d, cur_base1));
    end
    drain();

    if (mismatches == 0) begin
      $display("permutation_unrank verification clean");
    end else begin
      $display("permutation_unrank verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/pu_pkg.sv
src/pu_stream_if.sv
src/pu_ctrl.sv
src/pu_dp.sv
src/permutation_unrank.sv
dv/permutation_unrank_checker.sv
dv/permutation_unrank_tb.sv
